/* rtl/core/psme_pkg.sv */
`timescale 1ns / 1ps
// psme_pkg: shared widths, constants, types and back-end states of the
// schedule makespan evaluator. No dependencies.
package psme_pkg;

    localparam int TIME_W     = 24;
    localparam int PEN_W      = 9;
    localparam int WEIGHT_W   = 16;
    localparam int JOB_IN_W   = 8;
    localparam int MACH_IN_W  = 4;
    localparam int CNT_W      = 3;
    localparam int DEP_FIELDS = 4;
    localparam int DEP_SEL_W  = 2;
    // widest internal indexes over the supported parameter ranges
    localparam int JOB_IDX_W  = 12;
    localparam int MACH_IDX_W = 8;
    localparam int EPOCH_W    = 8;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = 1;
    localparam int QCNT_W     = 2;

    localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [PEN_W-1:0]   PEN_MAX   = {PEN_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_CLR = '0;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

    // one classified job word, indexes already reduced to the table depths
    typedef struct packed {
        logic [JOB_IDX_W-1:0]                 job;
        logic [MACH_IDX_W-1:0]                mach;
        logic [WEIGHT_W-1:0]                  weight;
        logic [CNT_W-1:0]                     cnt;
        logic [DEP_FIELDS-1:0][JOB_IDX_W-1:0] deps;
        logic                                 last;
    } t_task;

    // queue head as seen by the back end
    typedef struct packed {
        logic  vld;
        t_task word;
    } t_qhead;

    // job table entry: epoch tag marks the entry as scheduled in this schedule
    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [TIME_W-1:0]  fin;
    } t_jent;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_LOAD,
        S_DEP,
        S_CALC
    } t_bstate;

endpackage

/* rtl/core/psme_in_if.sv */
`timescale 1ns / 1ps
// psme_in_if: job word channel (valid/ready plus job fields).
// Depends on psme_pkg.
interface psme_in_if
    import psme_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [JOB_IN_W-1:0]   job_id;
    logic [MACH_IN_W-1:0]  machine;
    logic [WEIGHT_W-1:0]   weight;
    logic [CNT_W-1:0]      dep_count;
    logic [JOB_IN_W-1:0]   dep_a;
    logic [JOB_IN_W-1:0]   dep_b;
    logic [JOB_IN_W-1:0]   dep_c;
    logic [JOB_IN_W-1:0]   dep_d;
    logic                  last_job;

    modport source (
        output valid, job_id, machine, weight, dep_count,
               dep_a, dep_b, dep_c, dep_d, last_job,
        input  ready
    );
    modport sink (
        input  valid, job_id, machine, weight, dep_count,
               dep_a, dep_b, dep_c, dep_d, last_job,
        output ready
    );
endinterface

/* rtl/core/psme_out_if.sv */
`timescale 1ns / 1ps
// psme_out_if: score word channel (valid/ready plus makespan and penalty).
// Depends on psme_pkg.
interface psme_out_if
    import psme_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] makespan;
    logic [PEN_W-1:0]  penalty;

    modport source (output valid, makespan, penalty, input ready);
    modport sink (input valid, makespan, penalty, output ready);
endinterface

/* rtl/core/psme_front.sv */
`timescale 1ns / 1ps
// psme_front: accepts job words, reduces ids to table depths, clamps the
// dependency count and pushes the result into the queue. Depends on psme_pkg.
module psme_front
    import psme_pkg::*;
#(
    parameter int MAX_JOBS     = 256,
    parameter int MAX_MACHINES = 16,
    parameter int MAX_DEPS     = 4
) (
    psme_in_if.sink i_sched,
    input  logic    i_full,
    output logic    o_push,
    output t_task   o_word
);

    localparam int DEP_LIM = (MAX_DEPS < DEP_FIELDS) ? MAX_DEPS : DEP_FIELDS;
    localparam int RED_W   = 20;
    // reciprocal scaling for the constant remainders
    localparam int RSH         = 16;
    localparam int RCP_W       = 17;
    localparam int JPROD_W     = JOB_IN_W + RCP_W;
    localparam int MPROD_W     = MACH_IN_W + RCP_W;
    localparam logic [RCP_W-1:0] JOB_RCP  = RCP_W'((1 << RSH) / MAX_JOBS);
    localparam logic [RCP_W-1:0] MACH_RCP = RCP_W'((1 << RSH) / MAX_MACHINES);

    // remainder by reciprocal multiplication: the quotient estimate is exact
    // or one low, so a single compare and subtract finishes it
    function automatic logic [JOB_IDX_W-1:0] f_mod_job(input logic [JOB_IN_W-1:0] v);
        logic [JPROD_W-1:0]  p;
        logic [JOB_IN_W-1:0] q;
        logic [RED_W-1:0]    r;
        p = JPROD_W'(v) * JPROD_W'(JOB_RCP);
        q = p[RSH +: JOB_IN_W];
        r = RED_W'(v) - RED_W'(q) * RED_W'(MAX_JOBS);
        if (r >= RED_W'(MAX_JOBS)) begin
            r = r - RED_W'(MAX_JOBS);
        end
        return r[JOB_IDX_W-1:0];
    endfunction

    function automatic logic [MACH_IDX_W-1:0] f_mod_mach(input logic [MACH_IN_W-1:0] v);
        logic [MPROD_W-1:0]   p;
        logic [MACH_IN_W-1:0] q;
        logic [RED_W-1:0]     r;
        p = MPROD_W'(v) * MPROD_W'(MACH_RCP);
        q = p[RSH +: MACH_IN_W];
        r = RED_W'(v) - RED_W'(q) * RED_W'(MAX_MACHINES);
        if (r >= RED_W'(MAX_MACHINES)) begin
            r = r - RED_W'(MAX_MACHINES);
        end
        return r[MACH_IDX_W-1:0];
    endfunction

    assign i_sched.ready = !i_full;
    assign o_push        = i_sched.valid && !i_full;

    always_comb begin
        o_word.job     = f_mod_job(i_sched.job_id);
        o_word.mach    = f_mod_mach(i_sched.machine);
        o_word.weight  = i_sched.weight;
        o_word.cnt     = (i_sched.dep_count > CNT_W'(DEP_LIM)) ? CNT_W'(DEP_LIM)
                                                               : i_sched.dep_count;
        o_word.deps[0] = f_mod_job(i_sched.dep_a);
        o_word.deps[1] = f_mod_job(i_sched.dep_b);
        o_word.deps[2] = f_mod_job(i_sched.dep_c);
        o_word.deps[3] = f_mod_job(i_sched.dep_d);
        o_word.last    = i_sched.last_job;
    end

endmodule

/* rtl/core/psme_queue.sv */
`timescale 1ns / 1ps
// psme_queue: two-entry word queue between front and back end.
// Depends on psme_pkg.
module psme_queue
    import psme_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_task  i_word,
    input  logic   i_pop,
    output logic   o_full,
    output t_qhead o_head
);

    t_task               r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wp;
    logic [QPTR_W-1:0]   r_rp;
    logic [QCNT_W-1:0]   r_cnt;
    logic [QCNT_W-1:0]   n_cnt;

    assign o_full      = (r_cnt == QCNT_W'(QDEPTH));
    assign o_head.vld  = (r_cnt != '0);
    assign o_head.word = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_word;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");
    a_no_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != '0)
        else $error("pop from empty queue");
    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_cnt == $past(r_cnt) + QCNT_W'(1))
        else $error("push lost");

endmodule

/* rtl/core/psme_back.sv */
`timescale 1ns / 1ps
// psme_back: sequencer that reads dependency finish times, schedules the job,
// keeps the running score and holds the score word. Depends on psme_pkg.
module psme_back
    import psme_pkg::*;
#(
    parameter int MAX_JOBS     = 256,
    parameter int MAX_MACHINES = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_qhead i_head,
    output logic   o_pop,
    psme_out_if.source o_score
);

    localparam int JW = $clog2(MAX_JOBS);
    localparam int MW = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;

    // job finish-time table and machine free-time table
    t_jent             jmem [MAX_JOBS];
    logic [TIME_W-1:0] mmem [MAX_MACHINES];

    t_bstate             r_state;
    t_bstate             n_state;
    logic [JW-1:0]       r_clr;
    logic [JW-1:0]       n_clr;
    logic [EPOCH_W-1:0]  r_epoch;
    logic [EPOCH_W-1:0]  n_epoch;
    t_task               r_task;
    logic [CNT_W-1:0]    r_i;
    logic                r_pend;
    t_jent               r_jrd;
    logic [TIME_W-1:0]   r_mrd;
    logic                r_mv;
    logic [MAX_MACHINES-1:0] r_mvld;
    logic [TIME_W-1:0]   r_early;
    logic                r_miss;
    logic [TIME_W-1:0]   r_ms;
    logic [PEN_W-1:0]    r_pen;
    logic                r_out_vld;
    logic [TIME_W-1:0]   r_out_ms;
    logic [PEN_W-1:0]    r_out_pen;

    logic                j_ren;
    logic [JW-1:0]       j_raddr;
    logic                j_wen;
    logic [JW-1:0]       j_waddr;
    t_jent               j_wdata;
    logic                m_ren;
    logic                dep_issue;
    logic                calc_go;

    logic [TIME_W-1:0]   mfree;
    logic [TIME_W-1:0]   start;
    logic [TIME_W:0]     sum;
    logic [TIME_W-1:0]   finish;
    logic [TIME_W-1:0]   ms_next;
    logic [PEN_W-1:0]    pen_next;

    // finish time and score update of the job in r_task
    always_comb begin
        mfree    = r_mv ? r_mrd : '0;
        start    = (mfree > r_early) ? mfree : r_early;
        sum      = {1'b0, start} + (TIME_W + 1)'(r_task.weight);
        finish   = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
        ms_next  = (finish > r_ms) ? finish : r_ms;
        pen_next = (r_miss && (r_pen != PEN_MAX)) ? r_pen + PEN_W'(1) : r_pen;
    end

    assign n_clr   = (r_clr == JW'(MAX_JOBS - 1)) ? '0 : r_clr + JW'(1);
    assign n_epoch = (r_epoch == EPOCH_MAX) ? EPOCH_FIRST : r_epoch + EPOCH_W'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == JW'(MAX_JOBS - 1)) n_state = S_LOAD;
            S_LOAD:  if (i_head.vld) n_state = S_DEP;
            S_DEP:   if (r_i >= r_task.cnt) n_state = S_CALC;
            S_CALC: begin
                if (calc_go) begin
                    n_state = (r_task.last && (r_epoch == EPOCH_MAX)) ? S_CLEAR : S_LOAD;
                end
            end
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        j_ren     = 1'b0;
        j_raddr   = i_head.word.deps[0][JW-1:0];
        j_wen     = 1'b0;
        j_waddr   = r_clr;
        j_wdata   = '{tag: EPOCH_CLR, fin: '0};
        m_ren     = 1'b0;
        dep_issue = 1'b0;
        calc_go   = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                j_wen = 1'b1;
            end
            S_LOAD: begin
                if (i_head.vld) begin
                    o_pop = 1'b1;
                    m_ren = 1'b1;
                    j_ren = (i_head.word.cnt != '0);
                end
            end
            S_DEP: begin
                if (r_i < r_task.cnt) begin
                    dep_issue = 1'b1;
                    j_ren     = 1'b1;
                    j_raddr   = r_task.deps[r_i[DEP_SEL_W-1:0]][JW-1:0];
                end
            end
            S_CALC: begin
                calc_go = !r_task.last || !r_out_vld || o_score.ready;
                if (calc_go) begin
                    j_wen   = 1'b1;
                    j_waddr = r_task.job[JW-1:0];
                    j_wdata = '{tag: r_epoch, fin: finish};
                end
            end
        endcase
    end

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (j_wen) begin
            jmem[j_waddr] <= j_wdata;
        end
        if (j_ren) begin
            r_jrd <= jmem[j_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (calc_go) begin
            mmem[r_task.mach[MW-1:0]] <= finish;
        end
        if (m_ren) begin
            r_mrd <= mmem[i_head.word.mach[MW-1:0]];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_epoch   <= EPOCH_FIRST;
            r_i       <= '0;
            r_pend    <= 1'b0;
            r_mvld    <= '0;
            r_ms      <= '0;
            r_pen     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= n_clr;
            end
            if (o_pop) begin
                r_i    <= (i_head.word.cnt != '0) ? CNT_W'(1) : '0;
                r_pend <= (i_head.word.cnt != '0);
            end else if (r_state == S_DEP) begin
                r_pend <= dep_issue;
                if (dep_issue) begin
                    r_i <= r_i + CNT_W'(1);
                end
            end
            if (calc_go) begin
                if (r_task.last) begin
                    r_ms    <= '0;
                    r_pen   <= '0;
                    r_mvld  <= '0;
                    r_epoch <= n_epoch;
                end else begin
                    r_ms  <= ms_next;
                    r_pen <= pen_next;
                    r_mvld[r_task.mach[MW-1:0]] <= 1'b1;
                end
            end
            if (calc_go && r_task.last) begin
                r_out_vld <= 1'b1;
            end else if (o_score.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload state
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_task  <= i_head.word;
            r_mv    <= r_mvld[i_head.word.mach[MW-1:0]];
            r_early <= '0;
            r_miss  <= 1'b0;
        end else if (r_pend) begin
            if (r_jrd.tag == r_epoch) begin
                if (r_jrd.fin > r_early) begin
                    r_early <= r_jrd.fin;
                end
            end else begin
                r_miss <= 1'b1;
            end
        end
        if (calc_go && r_task.last) begin
            r_out_ms  <= ms_next;
            r_out_pen <= pen_next;
        end
    end

    assign o_score.valid    = r_out_vld;
    assign o_score.makespan = r_out_ms;
    assign o_score.penalty  = r_out_pen;

    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != EPOCH_CLR)
        else $error("epoch tag collides with cleared entries");
    a_pend_dep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_state == S_DEP)
        else $error("dependency read in flight outside dependency phase");
    a_dep_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEP) |-> r_i <= r_task.cnt)
        else $error("dependency index past count");
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_pop)
        else $error("job taken during clearing pass");
    a_score_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (calc_go && r_task.last) |=> r_out_vld)
        else $error("score word not presented");

endmodule

/* rtl/core/precedence_schedule_makespan_eval_unit.sv */
`timescale 1ns / 1ps
// precedence_schedule_makespan_eval_unit: top level of the schedule scorer.
// Depends on psme_pkg, psme_in_if, psme_out_if, psme_front, psme_queue, psme_back.

// Scores one candidate schedule streamed in schedule order, one job word per
// handshake on i_sched. Each job starts at the later of its machine's free time
// and the latest finish time of its scheduled prerequisites, and finishes
// weight units later (saturating at 24 bits). A prerequisite not yet placed in
// the current schedule counts as time 0 and marks the job late; the penalty
// counts late jobs (saturating at 511). The word flagged last_job produces one
// score word on o_score (makespan, penalty) and clears the per-schedule state;
// other words produce nothing. Ids are reduced modulo MAX_JOBS / MAX_MACHINES
// and the dependency count is clamped to min(MAX_DEPS, 4).
// Timing: the front end classifies a word in the accepting cycle and places it
// in a two-entry queue, so i_sched.ready only drops when that queue is full.
// The back end takes one job at a time through S_LOAD, S_DEP and S_CALC,
// and the job finish-time memory serves one dependency read per cycle.
// A score word waits in an output register; only a last word stalls
// while a previous score has not been taken. After reset, and again after
// every 255th schedule when the schedule tag wraps, a clearing pass
// sweeps every finish-time memory entry while no job words are taken.
module precedence_schedule_makespan_eval_unit
    import psme_pkg::*;
#(
    parameter int MAX_JOBS     = 256,
    parameter int MAX_MACHINES = 16,
    parameter int MAX_DEPS     = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    psme_in_if.sink     i_sched,
    psme_out_if.source  o_score
);

    // front -> queue
    logic   push;
    t_task  push_word;
    logic   q_full;
    // queue -> back
    t_qhead q_head;
    logic   q_pop;

    psme_front #(
        .MAX_JOBS     (MAX_JOBS),
        .MAX_MACHINES (MAX_MACHINES),
        .MAX_DEPS     (MAX_DEPS)
    ) u_front (
        .i_sched (i_sched),
        .i_full  (q_full),
        .o_push  (push),
        .o_word  (push_word)
    );

    psme_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    psme_back #(
        .MAX_JOBS     (MAX_JOBS),
        .MAX_MACHINES (MAX_MACHINES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .o_score (o_score)
    );

endmodule

/* tb/precedence_schedule_makespan_eval_unit_tb.sv */
`timescale 1ns / 1ps
// precedence_schedule_makespan_eval_unit_tb: self-checking bench for the schedule scorer.
// Streams job words, predicts makespan and penalty per schedule, checks each score word.
// Depends on psme_pkg, psme_in_if, psme_out_if and precedence_schedule_makespan_eval_unit.
module precedence_schedule_makespan_eval_unit_tb;
    import psme_pkg::*;

    localparam int JOB_DEPTH    = 256;
    localparam int MACH_DEPTH   = 16;
    localparam int DEP_LIMIT    = 4;
    localparam int DEP_USED     = (DEP_LIMIT < DEP_FIELDS) ? DEP_LIMIT : DEP_FIELDS;
    localparam int ITEM_TARGET  = 1150;
    // more schedules than one tag period, so the wrap clearing pass runs
    localparam int SCHED_TARGET = 262;
    // long enough to saturate both the finish time and the penalty
    localparam int LONG_LEN     = 530;
    localparam int MAX_WAIT     = 16;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [JOB_IN_W-1:0]                 job_id;
        logic [MACH_IN_W-1:0]                machine;
        logic [WEIGHT_W-1:0]                 weight;
        logic [CNT_W-1:0]                    dep_count;
        logic [DEP_FIELDS-1:0][JOB_IN_W-1:0] deps;    // deps[0] is dep_a
        logic                                last_job;
    } t_job_word;

    typedef struct packed {
        logic [TIME_W-1:0] makespan;
        logic [PEN_W-1:0]  penalty;
    } t_score;

    logic i_clk;
    logic i_rst_n;

    psme_in_if  sched_if ();
    psme_out_if score_if ();

    precedence_schedule_makespan_eval_unit #(
        .MAX_JOBS     (JOB_DEPTH),
        .MAX_MACHINES (MACH_DEPTH),
        .MAX_DEPS     (DEP_LIMIT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sched (sched_if),
        .o_score (score_if)
    );

    // ------------------------------------------------------------------
    // Schedule model: machine free times, job finish times, placed marks,
    // running makespan and late-job count of the schedule in progress.
    // ------------------------------------------------------------------
    logic [TIME_W-1:0] mach_free_at [MACH_DEPTH];
    logic [TIME_W-1:0] job_done_at  [JOB_DEPTH];
    bit                job_placed   [JOB_DEPTH];
    logic [TIME_W-1:0] span_so_far;
    logic [PEN_W-1:0]  late_jobs;

    t_job_word pending_jobs [$];     // words not yet put on the bus
    t_score    expected_scores [$];  // one per accepted last word, oldest first
    t_job_word on_bus;               // word currently offered on i_sched
    t_score    want_score;

    int total_words;
    int accepted_words;
    int send_wait;
    int recv_wait;
    bit send_calm;
    bit recv_calm;
    int cycle_cnt;
    int err_cnt;

    task automatic start_new_schedule();
        for (int m = 0; m < MACH_DEPTH; m++) mach_free_at[m] = '0;
        for (int j = 0; j < JOB_DEPTH; j++) job_placed[j] = 1'b0;
        span_so_far = '0;
        late_jobs   = '0;
    endtask

    // Place one accepted job word into the model schedule; a last word
    // closes the schedule and yields the expected score word.
    task automatic place_job(input t_job_word w);
        int unsigned       n_deps;
        int unsigned       dep_idx;
        int unsigned       job_idx;
        int unsigned       mach_idx;
        logic [TIME_W-1:0] deps_done;
        logic [TIME_W-1:0] start_at;
        logic [TIME_W-1:0] done_at;
        logic [TIME_W:0]   sum;
        bit                late;
        t_score            s;
        n_deps    = (w.dep_count > DEP_USED) ? DEP_USED : w.dep_count;
        job_idx   = w.job_id % JOB_DEPTH;
        mach_idx  = w.machine % MACH_DEPTH;
        deps_done = '0;
        late      = 1'b0;
        for (int i = 0; i < n_deps; i++) begin
            dep_idx = w.deps[i] % JOB_DEPTH;
            if (!job_placed[dep_idx]) begin
                late = 1'b1;           // unplaced prerequisite counts as time 0
            end else if (job_done_at[dep_idx] > deps_done) begin
                deps_done = job_done_at[dep_idx];
            end
        end
        start_at = (mach_free_at[mach_idx] > deps_done) ? mach_free_at[mach_idx] : deps_done;
        sum      = {1'b0, start_at} + w.weight;
        done_at  = (sum > TIME_MAX) ? TIME_MAX : sum[TIME_W-1:0];
        mach_free_at[mach_idx] = done_at;
        job_done_at[job_idx]   = done_at;
        job_placed[job_idx]    = 1'b1;
        if (done_at > span_so_far) span_so_far = done_at;
        if (late && late_jobs < PEN_MAX) late_jobs = late_jobs + 1'b1;
        if (w.last_job) begin
            s.makespan = span_so_far;
            s.penalty  = late_jobs;
            expected_scores = {expected_scores, s};
            start_new_schedule();
        end
    endtask

    task automatic queue_job(input int job, input int mach, input int wt, input int cnt,
                             input int a, input int b, input int c, input int d,
                             input bit is_last);
        t_job_word w;
        w.job_id    = JOB_IN_W'(job);
        w.machine   = MACH_IN_W'(mach);
        w.weight    = WEIGHT_W'(wt);
        w.dep_count = CNT_W'(cnt);
        w.deps      = {JOB_IN_W'(d), JOB_IN_W'(c), JOB_IN_W'(b), JOB_IN_W'(a)};
        w.last_job  = is_last;
        pending_jobs = {pending_jobs, w};
    endtask

    // clock: 20 ns period
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Driver: offers queued job words; after each accepted word it may idle
    // at random before the next, with calm stretches where it idles not at all.
    // The model is advanced at the edge where a word is taken.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sched_if.valid <= 1'b0;
            send_wait = 0;
        end else if (!sched_if.valid || sched_if.ready) begin
            if (sched_if.valid) begin
                place_job(on_bus);
                accepted_words++;
                if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
                send_wait = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (send_wait != 0) begin
                send_wait--;
                sched_if.valid <= 1'b0;
            end else if (pending_jobs.size() != 0) begin
                on_bus = pending_jobs.pop_front();
                sched_if.valid     <= 1'b1;
                sched_if.job_id    <= on_bus.job_id;
                sched_if.machine   <= on_bus.machine;
                sched_if.weight    <= on_bus.weight;
                sched_if.dep_count <= on_bus.dep_count;
                sched_if.dep_a     <= on_bus.deps[0];
                sched_if.dep_b     <= on_bus.deps[1];
                sched_if.dep_c     <= on_bus.deps[2];
                sched_if.dep_d     <= on_bus.deps[3];
                sched_if.last_job  <= on_bus.last_job;
            end else begin
                sched_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: takes score words, after each one at random holding ready low,
    // and checks every word against the oldest expected score.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            score_if.ready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (score_if.valid && score_if.ready) begin
                if (expected_scores.size() == 0) begin
                    $error("score word with no schedule closed: makespan %0d, penalty %0d",
                           score_if.makespan, score_if.penalty);
                    err_cnt++;
                end else begin
                    want_score = expected_scores.pop_front();
                    if (score_if.makespan !== want_score.makespan) begin
                        $error("makespan: expected %0d, actual %0d",
                               want_score.makespan, score_if.makespan);
                        err_cnt++;
                    end
                    if (score_if.penalty !== want_score.penalty) begin
                        $error("penalty: expected %0d, actual %0d",
                               want_score.penalty, score_if.penalty);
                        err_cnt++;
                    end
                end
                if ($urandom_range(0, 31) == 0) recv_calm = !recv_calm;
                recv_wait = recv_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (recv_wait != 0) begin
                recv_wait--;
                score_if.ready <= 1'b0;
            end else begin
                score_if.ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("precedence_schedule_makespan_eval_unit_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run.
    // ------------------------------------------------------------------
    initial begin
        int placed [$];
        int dep [DEP_FIELDS];
        int n_sched;
        int len;
        int job;
        int mach;
        int wt;
        int cnt;
        int long_mach;
        bit narrow;

        i_rst_n            = 1'b0;
        sched_if.valid     = 1'b0;
        sched_if.job_id    = '0;
        sched_if.machine   = '0;
        sched_if.weight    = '0;
        sched_if.dep_count = '0;
        sched_if.dep_a     = '0;
        sched_if.dep_b     = '0;
        sched_if.dep_c     = '0;
        sched_if.dep_d     = '0;
        sched_if.last_job  = 1'b0;
        score_if.ready     = 1'b0;
        cycle_cnt          = 0;
        err_cnt            = 0;
        accepted_words     = 0;
        send_calm          = 1'b0;
        recv_calm          = 1'b0;
        for (int j = 0; j < JOB_DEPTH; j++) job_done_at[j] = '0;
        start_new_schedule();

        // Directed: every dependency count, field extremes, self dependency
        // before and after placement, repeated job, clamped count.
        queue_job(0,   0,  0,        0, 0,   0,   0,   0,   0);
        queue_job(255, 15, 16'hFFFF, 1, 0,   255, 255, 255, 0);
        queue_job(1,   15, 1,        2, 255, 0,   0,   0,   0);
        queue_job(2,   3,  100,      3, 1,   255, 2,   0,   0);
        queue_job(3,   3,  7,        4, 0,   1,   2,   255, 0);
        queue_job(2,   7,  5,        4, 2,   3,   0,   1,   0);
        queue_job(4,   0,  16'hFFFF, 7, 3,   200, 201, 202, 0);
        queue_job(5,   1,  9,        5, 250, 1,   4,   255, 1);
        // prerequisites left over from the schedule just closed are stale
        queue_job(0,   8,  16'h8000, 6, 0,   5,   4,   3,   1);
        // no prerequisites, unused fields all ones
        queue_job(77,  9,  16'hAAAA, 0, 255, 255, 255, 255, 1);
        // words without last_job keep accumulating
        queue_job(10,  2,  16'h5555, 1, 11,  0,   0,   0,   0);
        queue_job(11,  2,  16'hFFFF, 1, 10,  0,   0,   0,   0);
        queue_job(12,  8,  3,        2, 11,  10,  0,   0,   1);
        n_sched = 4;

        // One long chain on a single machine: every job late through an
        // upper-half prerequisite that is never placed, so the finish
        // time and the penalty both run into saturation.
        long_mach = $urandom_range(0, MACH_DEPTH - 1);
        for (int k = 0; k < LONG_LEN; k++) begin
            queue_job($urandom_range(0, 127), long_mach, $urandom_range(16'hFF00, 16'hFFFF),
                      $urandom_range(1, 4), $urandom_range(128, 255), $urandom_range(0, 127),
                      $urandom_range(0, 127), $urandom_range(0, 255), k == LONG_LEN - 1);
        end
        n_sched++;

        // Random schedules: mostly well formed (prerequisites drawn from jobs
        // already placed), with some stray ids, repeats, self dependencies
        // and oversized counts mixed in.
        while (pending_jobs.size() < ITEM_TARGET || n_sched < SCHED_TARGET) begin
            len    = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
            narrow = $urandom_range(0, 1);   // few machines -> more contention
            placed.delete();
            for (int k = 0; k < len; k++) begin
                mach = narrow ? $urandom_range(0, 3) : $urandom_range(0, MACH_DEPTH - 1);
                case ($urandom_range(0, 7))
                    0:       wt = 0;
                    1:       wt = 16'hFFFF;
                    default: wt = $urandom_range(0, 16'hFFFF);
                endcase
                if ($urandom_range(0, 9) == 0) begin
                    cnt = $urandom_range(0, 7);
                end else begin
                    cnt = $urandom_range(0, (placed.size() < DEP_FIELDS) ? placed.size()
                                                                         : DEP_FIELDS);
                end
                for (int j = 0; j < DEP_FIELDS; j++) begin
                    if (j < cnt && placed.size() != 0 && $urandom_range(0, 7) != 0) begin
                        dep[j] = placed[$urandom_range(0, placed.size() - 1)];
                    end else begin
                        dep[j] = $urandom_range(0, 255);
                    end
                end
                job = $urandom_range(0, 255);
                if ($urandom_range(0, 9) == 0 && placed.size() != 0) begin
                    job = placed[$urandom_range(0, placed.size() - 1)];
                end else if ($urandom_range(0, 15) == 0 && cnt != 0) begin
                    job = dep[0];
                end
                queue_job(job, mach, wt, cnt, dep[0], dep[1], dep[2], dep[3], k == len - 1);
                placed = {placed, job};
            end
            n_sched++;
        end
        total_words = pending_jobs.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_words < total_words || expected_scores.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("precedence_schedule_makespan_eval_unit_tb: clean");
        end else begin
            $display("precedence_schedule_makespan_eval_unit_tb: errors");
        end
        $finish;
    end

endmodule
